FILE: sv/optt_pkg.sv
// shared types and constants of the timer slot table
`timescale 1ns / 1ps
package optt_pkg;
  localparam int unsigned NUM_SLOTS = 16;
  localparam int unsigned SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned MAX_REPORTS = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    MODE_TICK    = 3'd0,
    MODE_ADD     = 3'd1,
    MODE_MODIFY  = 3'd2,
    MODE_REMOVE  = 3'd3,
    MODE_DISABLE = 3'd4,
    MODE_ENABLE  = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_USED = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic {
    KIND_ACK    = 1'b0,
    KIND_EXPIRY = 1'b1
  } kind_e;

  // command as it leaves the front part
  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  slot;
    logic [31:0] interval;
    logic        periodic;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic       kind;
    logic [1:0] status;
    logic [3:0] which_slot;
    logic       was_periodic;
    logic       last;
  } res_t;
endpackage

FILE: sv/oneshot_periodic_timer_table.sv
// top level of the timer slot table
//  channel | valid   | stall   | payload
//  in      | valid_i | stall_o | mode_i slot_i interval_i periodic_i
//  out     | valid_o | stall_i | kind_o status_o which_slot_o was_periodic_o last_o
// an item enters a two-entry queue; the back part takes it and registers its acknowledge
// a tick leaves idle and runs rounds of slot scan, select state and wait state
// each report is sent one round after it is found, and a final empty round ends the tick
// after the sixteenth report no further round runs and the held report is sent at once
// reset clears the time counter and all slot flags at once
// the back part waits while the output register is stalled, the queue then fills
`timescale 1ns / 1ps
module oneshot_periodic_timer_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [2:0]  mode_i,
  input  logic [3:0]  slot_i,
  input  logic [31:0] interval_i,
  input  logic        periodic_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic        kind_o,
  output logic [1:0]  status_o,
  output logic [3:0]  which_slot_o,
  output logic        was_periodic_o,
  output logic        last_o
);
  optt_pkg::cmd_t cmd;
  optt_pkg::res_t res;
  logic           cmd_valid, cmd_take;

  // command queue
  optt_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .mode_i, .slot_i, .interval_i,
    .periodic_i, .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take), .cmd_o(cmd)
  );

  // execution
  optt_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take),
    .cmd_i(cmd), .res_valid_o(valid_o), .res_stall_i(stall_i), .res_o(res)
  );

  assign kind_o         = res.kind;
  assign status_o       = res.status;
  assign which_slot_o   = res.which_slot;
  assign was_periodic_o = res.was_periodic;
  assign last_o         = res.last;
endmodule

FILE: sv/optt_front.sv
// input stage and command queue: drops unused modes, buffers commands
`timescale 1ns / 1ps
module optt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  logic [2:0]        mode_i,
  input  logic [3:0]        slot_i,
  input  logic [31:0]       interval_i,
  input  logic              periodic_i,
  output logic              cmd_valid_o,
  input  logic              cmd_take_i,
  output optt_pkg::cmd_t    cmd_o
);
  localparam int unsigned PW = $clog2(optt_pkg::QUEUE_DEPTH);

  optt_pkg::cmd_t        mem_q [optt_pkg::QUEUE_DEPTH];
  logic [PW-1:0]         wr_q, rd_q;
  logic [PW:0]           cnt_q;
  logic                  acc, keep;

  assign stall_o = (cnt_q == PW'(0) + (PW+1)'(optt_pkg::QUEUE_DEPTH));
  assign acc     = valid_i && !stall_o;
  // modes six and seven produce nothing and are dropped here
  assign keep    = (mode_i <= 3'(optt_pkg::MODE_ENABLE));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (acc && keep) begin
      mem_q[wr_q] <= '{mode: mode_i, slot: slot_i, interval: interval_i,
                       periodic: periodic_i};
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (acc && keep) wr_q <= wr_q + PW'(1);
      if (cmd_take_i) rd_q <= rd_q + PW'(1);
      cnt_q <= cnt_q + (PW+1)'(acc && keep) - (PW+1)'(cmd_take_i);
    end
  end
endmodule

FILE: sv/optt_back.sv
// command execution: slot table, time counter and expiry scan
`timescale 1ns / 1ps
module optt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_take_o,
  input  optt_pkg::cmd_t    cmd_i,
  output logic              res_valid_o,
  input  logic              res_stall_i,
  output optt_pkg::res_t    res_o
);
  localparam int unsigned N  = optt_pkg::NUM_SLOTS;
  localparam int unsigned SW = optt_pkg::SLOT_W;
  localparam int unsigned CW = $clog2(optt_pkg::MAX_REPORTS + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SEL   = 4'b0100,
    S_WAIT  = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [63:0]     now_q;
  logic [N-1:0]    in_use_q, armed_q, rep_q, done_q;
  logic [31:0]     per_mem [N];
  logic [63:0]     due_mem [N];
  logic [SW-1:0]   idx_q, best_q;
  logic            found_q;
  logic [63:0]     best_due_q;
  logic [CW-1:0]   nrep_q;
  logic            res_vld_q, res_vld_d;
  optt_pkg::res_t  res_q;
  // pending expiry report, held until its last flag is known
  logic            pend_q, pend_d;
  optt_pkg::res_t  pend_res_q;

  logic            out_free;
  logic [N-1:0]    free_v;
  logic [SW-1:0]   free_idx;
  logic            any_free;
  logic            sl_ok;
  logic [SW-1:0]   sl;
  logic            cand;
  logic            ack_go, tick_go;
  logic            rescan, emit_pend, pend_last;

  assign out_free    = !res_vld_q || !res_stall_i;
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  // lowest free slot
  assign free_v = ~in_use_q;
  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = N - 1; i >= 0; i--) begin
      if (free_v[i]) begin
        free_idx = SW'(i);
        any_free = 1'b1;
      end
    end
  end

  assign sl    = SW'(cmd_i.slot);
  assign sl_ok = ({28'd0, cmd_i.slot} < 32'(N)) && in_use_q[sl];
  assign cand  = in_use_q[idx_q] && armed_q[idx_q] && !done_q[idx_q] &&
                 (due_mem[idx_q] <= now_q);

  // commands are acknowledged at once, a tick starts a scan
  assign ack_go  = (state_q == S_IDLE) && cmd_valid_i && out_free && !pend_q &&
                   (cmd_i.mode != 3'(optt_pkg::MODE_TICK));
  assign tick_go = (state_q == S_IDLE) && cmd_valid_i && out_free && !pend_q &&
                   (cmd_i.mode == 3'(optt_pkg::MODE_TICK));
  assign cmd_take_o = ack_go || tick_go;

  // another round while reports are found and the cap is not reached
  assign rescan    = (state_q == S_WAIT) && out_free && found_q &&
                     (nrep_q < CW'(optt_pkg::MAX_REPORTS));
  assign emit_pend = pend_q && out_free && (state_q == S_IDLE || state_q == S_WAIT);
  assign pend_last = (state_q == S_IDLE) || !found_q;

  // control state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (tick_go) state_d = S_SCAN;
      S_SCAN: if (idx_q == SW'(N - 1)) state_d = S_SEL;
      S_SEL:  state_d = S_WAIT;
      S_WAIT: if (out_free) state_d = rescan ? S_SCAN : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // output valid and held report flag
  always_comb begin
    res_vld_d = (res_vld_q && res_stall_i) || ack_go || emit_pend;
    pend_d    = pend_q;
    if (state_q == S_IDLE && pend_q && out_free) pend_d = 1'b0;
    else if (state_q == S_WAIT && out_free) pend_d = found_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      now_q     <= '0;
      in_use_q  <= '0;
      armed_q   <= '0;
      rep_q     <= '0;
      done_q    <= '0;
      idx_q     <= '0;
      found_q   <= 1'b0;
      nrep_q    <= '0;
      res_vld_q <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      res_vld_q <= res_vld_d;
      pend_q    <= pend_d;
      unique case (state_q)
        S_IDLE: begin
          if (ack_go) begin
            if (cmd_i.mode == 3'(optt_pkg::MODE_ADD)) begin
              if (any_free) begin
                in_use_q[free_idx] <= 1'b1;
                armed_q[free_idx]  <= 1'b1;
                rep_q[free_idx]    <= cmd_i.periodic;
              end
            end else if (sl_ok) begin
              if (cmd_i.mode == 3'(optt_pkg::MODE_REMOVE)) begin
                in_use_q[sl] <= 1'b0;
                armed_q[sl]  <= 1'b0;
                rep_q[sl]    <= 1'b0;
              end else if (cmd_i.mode == 3'(optt_pkg::MODE_DISABLE)) begin
                armed_q[sl] <= 1'b0;
              end else if (cmd_i.mode == 3'(optt_pkg::MODE_ENABLE)) begin
                armed_q[sl] <= 1'b1;
              end
            end
          end else if (tick_go) begin
            now_q   <= now_q + 64'd1;
            done_q  <= '0;
            nrep_q  <= '0;
            idx_q   <= '0;
            found_q <= 1'b0;
          end
        end
        S_SCAN: begin
          // one slot a cycle: keep the earliest due, lowest slot on a tie
          if (cand && (!found_q || due_mem[idx_q] < best_due_q)) begin
            found_q <= 1'b1;
            best_q  <= idx_q;
          end
          if (idx_q != SW'(N - 1)) idx_q <= idx_q + SW'(1);
        end
        S_SEL: begin
          if (found_q) begin
            done_q[best_q] <= 1'b1;
            if (!rep_q[best_q]) begin
              in_use_q[best_q] <= 1'b0;
              armed_q[best_q]  <= 1'b0;
            end
            nrep_q <= nrep_q + CW'(1);
          end
        end
        S_WAIT: begin
          if (rescan) begin
            idx_q   <= '0;
            found_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (ack_go) begin
      res_q.kind         <= optt_pkg::KIND_ACK;
      res_q.was_periodic <= 1'b0;
      res_q.last         <= 1'b1;
      if (cmd_i.mode == 3'(optt_pkg::MODE_ADD)) begin
        res_q.status     <= any_free ? optt_pkg::ST_OK : optt_pkg::ST_FULL;
        res_q.which_slot <= any_free ? 4'(free_idx) : 4'd0;
      end else begin
        res_q.status     <= sl_ok ? optt_pkg::ST_OK : optt_pkg::ST_NOT_USED;
        res_q.which_slot <= cmd_i.slot;
      end
    end else if (emit_pend) begin
      // held report goes out, final when no further pick follows
      res_q <= '{kind: pend_res_q.kind, status: pend_res_q.status,
                 which_slot: pend_res_q.which_slot,
                 was_periodic: pend_res_q.was_periodic, last: pend_last};
    end
    if (state_q == S_WAIT && out_free && found_q)
      pend_res_q <= '{kind: optt_pkg::KIND_EXPIRY, status: optt_pkg::ST_OK,
                      which_slot: 4'(best_q), was_periodic: rep_q[best_q],
                      last: 1'b0};
    if (state_q == S_SCAN && cand && (!found_q || due_mem[idx_q] < best_due_q))
      best_due_q <= due_mem[idx_q];
  end

  // slot memories
  always_ff @(posedge clk_i) begin
    if (ack_go) begin
      if (cmd_i.mode == 3'(optt_pkg::MODE_ADD) && any_free) begin
        per_mem[free_idx] <= cmd_i.interval;
        due_mem[free_idx] <= now_q + {32'd0, cmd_i.interval};
      end else if (sl_ok && cmd_i.mode == 3'(optt_pkg::MODE_MODIFY)) begin
        per_mem[sl] <= cmd_i.interval;
        if (armed_q[sl]) due_mem[sl] <= now_q + {32'd0, cmd_i.interval};
      end else if (sl_ok && cmd_i.mode == 3'(optt_pkg::MODE_ENABLE)) begin
        due_mem[sl] <= now_q + {32'd0, per_mem[sl]};
      end
    end else if (state_q == S_SEL && found_q && rep_q[best_q]) begin
      due_mem[best_q] <= now_q + {32'd0, per_mem[best_q]};
    end
  end
endmodule

FILE: sv/optt_checker.sv
// port checker for the timer slot table
`timescale 1ns / 1ps
module optt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_o,
  input logic       stall_i,
  input logic       kind_o,
  input logic [1:0] status_o,
  input logic       was_periodic_o,
  input logic       last_o
);
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(last_o) && $stable(kind_o))
    else $error("stalled result changed");
  // acknowledges are single and final
  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && kind_o == 1'b0 |-> last_o)
    else $error("ack without last");
  // expiry reports carry ok status
  a_exp_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && kind_o |-> status_o == 2'd0)
    else $error("expiry with status");
  // acknowledges never flag periodic
  a_ack_per: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !kind_o |-> !was_periodic_o)
    else $error("ack flagged periodic");
endmodule

bind oneshot_periodic_timer_table optt_checker u_optt_checker (
  .clk_i, .rst_ni, .valid_o, .stall_i, .kind_o, .status_o, .was_periodic_o, .last_o
);

FILE: sim/tb_oneshot_periodic_timer_table.sv
// testbench of the timer slot table: random command bursts checked against a predictor
`timescale 1ns / 1ps
module tb_oneshot_periodic_timer_table;

  // result store: predicts results of each command and checks what comes out
  class timer_board;
    bit [63:0] now_ticks;
    bit        used [16];
    bit        enabled [16];
    bit        is_periodic [16];
    bit [31:0] ivl [16];
    bit [63:0] deadline [16];
    optt_pkg::res_t pending [$];
    int        errors;

    function new();
      now_ticks = '0;
      errors = 0;
      foreach (used[i]) begin
        used[i] = 0;
        enabled[i] = 0;
        is_periodic[i] = 0;
      end
    endfunction

    function void push(bit k, bit [1:0] st, bit [3:0] w, bit p, bit l);
      optt_pkg::res_t r;
      r.kind = k;
      r.status = st;
      r.which_slot = w;
      r.was_periodic = p;
      r.last = l;
      pending.push_back(r);
    endfunction

    // note one accepted command and queue the results it causes
    function void note_command(bit [2:0] m, bit [3:0] s, bit [31:0] iv, bit per);
      bit reported [16];
      int n;
      int best;
      bit placed;
      n = 0;
      placed = 0;
      if (m == optt_pkg::MODE_TICK) begin
        foreach (reported[i]) reported[i] = 0;
        now_ticks = now_ticks + 64'd1;
        while (n < optt_pkg::MAX_REPORTS) begin
          best = -1;
          for (int i = 0; i < 16; i++) begin
            if (!used[i] || !enabled[i] || reported[i] || deadline[i] > now_ticks) continue;
            if (best < 0 || deadline[i] < deadline[best]) best = i;
          end
          if (best < 0) break;
          reported[best] = 1;
          push(optt_pkg::KIND_EXPIRY, optt_pkg::ST_OK, best[3:0], is_periodic[best], 0);
          n++;
          if (is_periodic[best]) deadline[best] = now_ticks + 64'(ivl[best]);
          else begin
            used[best] = 0;
            enabled[best] = 0;
            is_periodic[best] = 0;
          end
        end
        if (n > 0) pending[pending.size()-1].last = 1;
      end else if (m == optt_pkg::MODE_ADD) begin
        for (int i = 0; i < 16 && !placed; i++) begin
          if (!used[i]) begin
            used[i] = 1;
            enabled[i] = 1;
            is_periodic[i] = per;
            ivl[i] = iv;
            deadline[i] = now_ticks + 64'(iv);
            push(optt_pkg::KIND_ACK, optt_pkg::ST_OK, i[3:0], 0, 1);
            placed = 1;
          end
        end
        if (!placed) push(optt_pkg::KIND_ACK, optt_pkg::ST_FULL, 4'd0, 0, 1);
      end else if (m <= optt_pkg::MODE_ENABLE) begin
        if (!used[s]) push(optt_pkg::KIND_ACK, optt_pkg::ST_NOT_USED, s, 0, 1);
        else begin
          case (m)
            optt_pkg::MODE_MODIFY: begin
              ivl[s] = iv;
              if (enabled[s]) deadline[s] = now_ticks + 64'(iv);
            end
            optt_pkg::MODE_REMOVE: begin
              used[s] = 0;
              enabled[s] = 0;
              is_periodic[s] = 0;
            end
            optt_pkg::MODE_DISABLE: enabled[s] = 0;
            default: begin
              enabled[s] = 1;
              deadline[s] = now_ticks + 64'(ivl[s]);
            end
          endcase
          push(optt_pkg::KIND_ACK, optt_pkg::ST_OK, s, 0, 1);
        end
      end
    endfunction

    // compare one result with the oldest expectation
    function void check_result(optt_pkg::res_t got);
      optt_pkg::res_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p got %p", exp_r, got);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        valid_i = 0;
  logic        stall_o;
  logic [2:0]  mode_i = '0;
  logic [3:0]  slot_i = '0;
  logic [31:0] interval_i = '0;
  logic        periodic_i = 0;
  logic        valid_o;
  logic        stall_i = 0;
  logic        kind_o;
  logic [1:0]  status_o;
  logic [3:0]  which_slot_o;
  logic        was_periodic_o;
  logic        last_o;

  timer_board board = new();
  int unsigned cycle_count = 0;
  localparam int unsigned CYCLE_LIMIT = 400000;

  oneshot_periodic_timer_table u_dut (.*);

  // clock
  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  // sample handshakes at the rising edge
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && valid_i && !stall_o) board.note_command(mode_i, slot_i, interval_i, periodic_i);
    if (rst_ni && valid_o && !stall_i)
      board.check_result({kind_o, status_o, which_slot_o, was_periodic_o, last_o});
  end

  // receiver stall pattern: calm stretches and busy stretches
  always @(negedge clk_i) begin
    if (cycle_count[9:8] == 2'b01) stall_i <= 0;
    else stall_i <= ($urandom_range(0, 3) == 0);
  end

  // timeout
  always @(posedge clk_i) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  int gap_left = 0;
  int burst_left = 0;

  // hand one item to the block, holding it until accepted
  task automatic send_item(bit [2:0] m, bit [3:0] s, bit [31:0] iv, bit per);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 20);
    end
    if (gap_left > 0) begin
      valid_i <= 0;
      repeat (gap_left) @(negedge clk_i);
    end
    gap_left = 0;
    burst_left--;
    valid_i <= 1;
    mode_i <= m;
    slot_i <= s;
    interval_i <= iv;
    periodic_i <= per;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic bit [31:0] pick_interval();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(0, 8);
    endcase
  endfunction

  task automatic random_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) send_item(optt_pkg::MODE_TICK, 4'($urandom()), $urandom(), 1'($urandom()));
    else if (r < 60)
      send_item(optt_pkg::MODE_ADD, 4'($urandom()), pick_interval(), 1'($urandom()));
    else if (r < 96)
      send_item(3'($urandom_range(optt_pkg::MODE_MODIFY, optt_pkg::MODE_ENABLE)),
                4'($urandom()), pick_interval(), 1'($urandom()));
    else send_item(3'($urandom_range(6, 7)), 4'($urandom()), $urandom(), 1'($urandom()));
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    // directed: empty tick, commands on empty slots, unused modes
    send_item(optt_pkg::MODE_TICK, 4'd0, 32'd0, 1'b0);
    send_item(optt_pkg::MODE_REMOVE, 4'd15, 32'd0, 1'b0);
    send_item(optt_pkg::MODE_ENABLE, 4'd3, 32'd0, 1'b0);
    send_item(3'd6, 4'd0, 32'd0, 1'b0);
    send_item(3'd7, 4'hF, 32'hFFFF_FFFF, 1'b1);
    // fill the table: zero and one intervals, every odd slot periodic, huge interval, then full
    for (int i = 0; i < 16; i++)
      send_item(optt_pkg::MODE_ADD, 4'd0,
                (i == 15) ? 32'hFFFF_FFFF : (i < 8 ? 32'd0 : 32'd1), i[0]);
    send_item(optt_pkg::MODE_ADD, 4'd0, 32'd5, 1'b1);
    // many due at once, then modify, disable, enable
    send_item(optt_pkg::MODE_TICK, 4'd0, 32'd0, 1'b0);
    send_item(optt_pkg::MODE_MODIFY, 4'd1, 32'd2, 1'b0);
    send_item(optt_pkg::MODE_DISABLE, 4'd3, 32'd0, 1'b0);
    send_item(optt_pkg::MODE_ENABLE, 4'd3, 32'd0, 1'b0);
    send_item(optt_pkg::MODE_ENABLE, 4'd3, 32'd0, 1'b0);
    send_item(optt_pkg::MODE_TICK, 4'd0, 32'd0, 1'b0);
    // random part
    for (int n = 0; n < 470; n++) random_command();
    valid_i <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
